// ----- hdl/swrl_pkg.sv -----
// Shared types and constants for the sliding window rate limiter.
// No dependencies; every other file in hdl/ imports this package.
package swrl_pkg;

    localparam int RING_DEPTH_DEF = 16;     // default number of stored stamps
    localparam int STAMP_W        = 32;     // timestamp and window width
    localparam int MAX_TX_W       = 16;     // width of max_transmits
    localparam int HITS_W         = 8;      // width of window_hits
    localparam int CFG_W          = 32;     // widest configuration register
    localparam int CFG_IDX_W      = 2;      // configuration index width

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANSMITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd2;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_COUNT  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

endpackage

// ----- hdl/swrl_in_if.sv -----
// Request channel of the rate limiter: valid/ready plus the request fields.
// Depends on swrl_pkg.
interface swrl_in_if;
    import swrl_pkg::*;

    logic                valid;
    logic                ready;
    t_op                 op;
    logic [STAMP_W-1:0]  now_seconds;
    logic [STAMP_W-1:0]  query_window;

    modport source (output valid, output op, output now_seconds, output query_window,
                    input ready);
    modport sink   (input valid, input op, input now_seconds, input query_window,
                    output ready);
endinterface

// ----- hdl/swrl_out_if.sv -----
// Result channel of the rate limiter: valid/ready plus the result fields.
// Depends on swrl_pkg.
interface swrl_out_if;
    import swrl_pkg::*;

    logic                valid;
    logic                ready;
    logic                blocked;
    logic [STAMP_W-1:0]  reschedule_in;
    logic [HITS_W-1:0]   window_hits;

    modport source (output valid, output blocked, output reschedule_in,
                    output window_hits, input ready);
    modport sink   (input valid, input blocked, input reschedule_in,
                    input window_hits, output ready);
endinterface

// ----- hdl/sliding_window_rate_limiter.sv -----
// Sliding window rate limiter: ring of transmit stamps scanned by one compare unit.
// Record, clear and disabled query go straight to the result; count and query scan the
// stored stamps (at most RING_DEPTH), one ring read a cycle, and a blocked query then
// computes the expiry and the reschedule delay before the result is handed over.
// Throughput: one request at a time; the next is taken once the result is presented.
// Reset (synchronous, active low) clears control, config and fill count; ring slots are kept.
module sliding_window_rate_limiter #(
    parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swrl_pkg::CFG_W-1:0]      i_cfg_data,
    swrl_in_if.sink                         i_in_ch,
    swrl_out_if.source                      o_out_ch
);
    import swrl_pkg::*;

    // slot pointer and fill count widths
    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    // sequencer: idle, scan the ring, add window to oldest, subtract now, hand over
    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_EXPIRY  = 5'b00100,
        S_RESCHED = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    // configuration registers
    logic                 r_limit_en;
    logic [MAX_TX_W-1:0]  r_max_tx;
    logic [STAMP_W-1:0]   r_win_sec;

    // ring control
    logic [PW-1:0]        r_wp,       n_wp;
    logic [CW-1:0]        r_count,    n_count;

    // sequencer and scan control
    t_state               r_state,    n_state;
    logic [CW-1:0]        r_issued,   n_issued;
    logic                 r_pend;
    logic                 w_issue;
    logic                 w_accept;
    logic                 w_load;
    logic                 r_out_valid, n_out_valid;

    // request and scan payload
    logic [STAMP_W-1:0]   r_ring [RING_DEPTH];
    logic [STAMP_W-1:0]   r_rd_data;
    t_op                  r_op;
    logic [STAMP_W-1:0]   r_now;
    logic [STAMP_W-1:0]   r_win;
    logic signed [STAMP_W:0] r_lower;
    logic [CW-1:0]        r_hits;
    logic [STAMP_W-1:0]   r_oldest;
    logic [STAMP_W:0]     r_expiry;
    logic                 r_res_blocked;
    logic [STAMP_W-1:0]   r_res_resched;
    logic [CW-1:0]        r_res_hits;
    logic                 r_out_blocked;
    logic [STAMP_W-1:0]   r_out_resched;
    logic [HITS_W-1:0]    r_out_hits;

    logic                 w_record_on;
    logic                 w_query_on;
    logic                 w_in_win;
    logic                 w_cap_hit;

    assign w_accept    = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = (r_state == S_IDLE);

    // recording needs the limiter on and a nonzero cap; a query also a window
    assign w_record_on = r_limit_en && (r_max_tx != '0);
    assign w_query_on  = w_record_on && (r_win_sec != '0);

    // one ring read per cycle until every stored slot has been issued
    assign w_issue     = (r_state == S_SCAN) && (r_issued < r_count);

    // shared compare unit: stamp not in the future and above the signed cutoff
    assign w_in_win    = (r_rd_data <= r_now) && ($signed({1'b0, r_rd_data}) > r_lower);
    assign w_cap_hit   = MAX_TX_W'(r_hits) >= r_max_tx;

    // result register loads when empty or when the sink takes the current one
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_out_ch.ready);

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_count     = r_count;
        n_issued    = r_issued;
        n_out_valid = r_out_valid;
        if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_issued = '0;
                    case (i_in_ch.op)
                        OP_RECORD: begin
                            if (w_record_on) begin
                                n_wp = (r_wp == PW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                                if (r_count != CW'(RING_DEPTH)) begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                            n_state = S_DONE;
                        end
                        OP_QUERY: begin
                            n_state = w_query_on ? S_SCAN : S_DONE;
                        end
                        OP_COUNT: begin
                            n_state = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_wp    = '0;
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_issued = r_issued + 1'b1;
                end else if (!r_pend) begin
                    // all entries seen: a query at the cap goes on to the expiry
                    n_state = ((r_op == OP_QUERY) && w_cap_hit) ? S_EXPIRY : S_DONE;
                end
            end
            S_EXPIRY: begin
                n_state = S_RESCHED;
            end
            S_RESCHED: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_count     <= '0;
            r_issued    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit_en  <= 1'b0;
            r_max_tx    <= '0;
            r_win_sec   <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_issued    <= n_issued;
            r_pend      <= w_issue;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIMIT_ENABLE:   r_limit_en <= i_cfg_data[0];
                    CFG_MAX_TRANSMITS:  r_max_tx   <= i_cfg_data[MAX_TX_W-1:0];
                    CFG_WINDOW_SECONDS: r_win_sec  <= i_cfg_data[STAMP_W-1:0];
                    default: begin
                        // unmapped index: drop the write
                    end
                endcase
            end
        end
    end

    // ring memory: one write port at the write pointer, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_ch.op == OP_RECORD) && w_record_on) begin
            r_ring[r_wp] <= i_in_ch.now_seconds;
        end
        r_rd_data <= r_ring[r_issued[PW-1:0]];
    end

    // request, scan and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op          <= i_in_ch.op;
            r_now         <= i_in_ch.now_seconds;
            // a query uses the configured window, a count the supplied one
            r_win         <= (i_in_ch.op == OP_QUERY) ? r_win_sec : i_in_ch.query_window;
            r_lower       <= $signed({1'b0, i_in_ch.now_seconds})
                           - $signed({1'b0, ((i_in_ch.op == OP_QUERY) ? r_win_sec
                                                                       : i_in_ch.query_window)});
            r_hits        <= '0;
            r_oldest      <= '0;
            r_res_blocked <= 1'b0;
            r_res_resched <= '0;
            r_res_hits    <= '0;
        end
        // fold in the stamp read last cycle: count it and keep the minimum
        if (r_state == S_SCAN && r_pend && w_in_win) begin
            r_hits <= r_hits + 1'b1;
            if (r_hits == '0 || r_rd_data < r_oldest) begin
                r_oldest <= r_rd_data;
            end
        end
        if (r_state == S_SCAN && !w_issue && !r_pend) begin
            r_res_hits <= r_hits;
            if (r_op == OP_QUERY && w_cap_hit) begin
                r_res_blocked <= 1'b1;
            end
        end
        if (r_state == S_EXPIRY) begin
            r_expiry <= {1'b0, r_oldest} + {1'b0, r_win};
        end
        if (r_state == S_RESCHED) begin
            // at least one second, even when the oldest entry has just expired
            if (r_expiry > {1'b0, r_now}) begin
                r_res_resched <= STAMP_W'(r_expiry - {1'b0, r_now});
            end else begin
                r_res_resched <= STAMP_W'(1);
            end
        end
        if (w_load) begin
            r_out_blocked <= r_res_blocked;
            r_out_resched <= r_res_resched;
            r_out_hits    <= HITS_W'(r_res_hits);
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.blocked       = r_out_blocked;
    assign o_out_ch.reschedule_in = r_out_resched;
    assign o_out_ch.window_hits   = r_out_hits;

    // fill count never passes the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    // write pointer stays inside the ring
    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PW'(RING_DEPTH - 1))
        else $error("write pointer outside ring");

    // a transfer in closes the request side until the result is handed over
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in_ch.ready)
        else $error("request taken while busy");

    // a blocked result always carries a nonzero delay, an unblocked one none
    a_resched_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_blocked == (r_out_resched != '0)))
        else $error("reschedule delay does not match blocked flag");

    // the scan never issues a read past the fill count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued <= r_count)
        else $error("scan ran past stored entries");

endmodule

// ----- tb/swrl_verdict_checker.sv -----
// Scoreboard for the sliding window rate limiter: mirrors the stamp ring and registers,
// predicts each verdict and compares it with what comes out. Depends on swrl_pkg and
// on the swrl_in_if / swrl_out_if channel interfaces.
module swrl_verdict_checker #(
    parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swrl_pkg::CFG_W-1:0]      i_cfg_data,
    swrl_in_if                              i_req_ch,
    swrl_out_if                             i_rsp_ch,
    output int                              o_fail_count,
    output int                              o_outstanding,
    output int                              o_blocked_seen
);
    import swrl_pkg::*;

    typedef struct packed {
        logic               blocked;
        logic [STAMP_W-1:0] reschedule_in;
        logic [HITS_W-1:0]  window_hits;
    } t_verdict;

    logic [STAMP_W-1:0]  stamp_log [RING_DEPTH];
    int                  wr_slot;
    int                  fill_level;
    logic                lim_en;
    logic [MAX_TX_W-1:0] cap;
    logic [STAMP_W-1:0]  span;
    t_verdict            awaited_verdicts [$];
    int                  fails;
    int                  blocked_seen;

    // count stamps in (now - win, now]; the floor is signed so it may go below zero
    function automatic logic [HITS_W-1:0] hits_in_window(input logic [STAMP_W-1:0] now,
                                                         input logic [STAMP_W-1:0] win,
                                                         output logic [STAMP_W-1:0] oldest);
        longint            floor_t;
        logic [HITS_W-1:0] hits;
        floor_t = $signed({32'd0, now}) - $signed({32'd0, win});
        hits    = '0;
        oldest  = '0;
        for (int i = 0; i < fill_level; i++) begin
            if (stamp_log[i] <= now && $signed({32'd0, stamp_log[i]}) > floor_t) begin
                if (hits == 0 || stamp_log[i] < oldest)
                    oldest = stamp_log[i];
                hits++;
            end
        end
        return hits;
    endfunction

    // advance the mirrored state by one request and return its verdict
    function automatic t_verdict apply_request(input t_op op, input logic [STAMP_W-1:0] now,
                                               input logic [STAMP_W-1:0] qwin);
        t_verdict           v;
        logic [STAMP_W-1:0] oldest;
        logic [63:0]        expiry;
        v = '0;
        case (op)
            OP_RECORD: begin
                if (lim_en && cap != 0) begin
                    stamp_log[wr_slot] = now;
                    wr_slot = (wr_slot + 1) % RING_DEPTH;
                    if (fill_level < RING_DEPTH)
                        fill_level++;
                end
            end
            OP_QUERY: begin
                if (lim_en && cap != 0 && span != 0) begin
                    v.window_hits = hits_in_window(now, span, oldest);
                    if (v.window_hits >= cap) begin
                        v.blocked = 1'b1;
                        expiry    = {32'd0, oldest} + {32'd0, span};
                        if (expiry > {32'd0, now})
                            v.reschedule_in = STAMP_W'(expiry - {32'd0, now});
                        else
                            v.reschedule_in = 1;
                    end
                end
            end
            OP_COUNT: begin
                v.window_hits = hits_in_window(now, qwin, oldest);
            end
            default: begin
                for (int i = 0; i < RING_DEPTH; i++)
                    stamp_log[i] = '0;
                wr_slot    = 0;
                fill_level = 0;
            end
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            wr_slot    = 0;
            fill_level = 0;
            lim_en     = 1'b0;
            cap        = '0;
            span       = '0;
            awaited_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIMIT_ENABLE:   lim_en = i_cfg_data[0];
                    CFG_MAX_TRANSMITS:  cap    = i_cfg_data[MAX_TX_W-1:0];
                    CFG_WINDOW_SECONDS: span   = i_cfg_data[STAMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_rsp_ch.valid && i_rsp_ch.ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $error("verdict transfer with no request outstanding");
                    fails++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (i_rsp_ch.blocked !== want.blocked) begin
                        $error("blocked: expected %0d, got %0d", want.blocked,
                               i_rsp_ch.blocked);
                        fails++;
                    end
                    if (i_rsp_ch.reschedule_in !== want.reschedule_in) begin
                        $error("reschedule_in: expected %0d, got %0d",
                               want.reschedule_in, i_rsp_ch.reschedule_in);
                        fails++;
                    end
                    if (i_rsp_ch.window_hits !== want.window_hits) begin
                        $error("window_hits: expected %0d, got %0d",
                               want.window_hits, i_rsp_ch.window_hits);
                        fails++;
                    end
                    if (want.blocked)
                        blocked_seen++;
                end
            end
            if (i_req_ch.valid && i_req_ch.ready)
                awaited_verdicts.push_back(apply_request(i_req_ch.op, i_req_ch.now_seconds,
                                                         i_req_ch.query_window));
        end
        o_outstanding  <= awaited_verdicts.size();
        o_fail_count   <= fails;
        o_blocked_seen <= blocked_seen;
    end

endmodule

// ----- tb/sliding_window_rate_limiter_tb.sv -----
// Top of the rate limiter testbench: clock, reset, register writes, request stimulus
// and result back-pressure. Depends on swrl_pkg, the channel interfaces, the RTL
// and swrl_verdict_checker, which does all prediction and comparison.
module sliding_window_rate_limiter_tb;
    import swrl_pkg::*;

    localparam int RING_DEPTH  = RING_DEPTH_DEF;
    localparam int PHASE_ITEMS = 64;       // random requests per register setting
    localparam int TAIL_CYCLES = 40;       // quiet spell after the last verdict
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    swrl_in_if  req_ch ();
    swrl_out_if rsp_ch ();

    int fail_count;
    int outstanding;
    int blocked_seen;
    int cycle_count = 0;
    int sent_per_op [4];
    int settings_run = 0;
    int stall_left = 0;
    bit stall_on = 1'b1;    // result side may hold off ready
    bit gaps_on = 1'b0;     // request side may insert idle cycles

    sliding_window_rate_limiter #(.RING_DEPTH(RING_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (req_ch),
        .o_out_ch    (rsp_ch)
    );

    swrl_verdict_checker #(.RING_DEPTH(RING_DEPTH)) verdict_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_ch       (req_ch),
        .i_rsp_ch       (rsp_ch),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_blocked_seen (blocked_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abandon the run if it hangs; nothing legal comes near this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d verdicts outstanding",
                     cycle_count, outstanding);
            $display("sliding_window_rate_limiter_tb failed");
            $finish;
        end
    end

    // Idle spell length: usually from the shortest band, now and then from the longest.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        else if (roll < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result back-pressure: drop ready for random spells, and toggle whole stretches
    // of stall-free running so that both regimes get exercised. Hold ready low in reset.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                stall_on <= !stall_on;
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= idle_length() - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the transfer happens. Valid stays high
    // between back-to-back requests; it only drops for an idle spell.
    task automatic send_request(input t_op op, input logic [STAMP_W-1:0] now,
                                input logic [STAMP_W-1:0] qwin);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.now_seconds  <= now;
        req_ch.query_window <= qwin;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sent_per_op[op]++;
    endtask

    // Stop offering and wait for every predicted verdict to arrive. The first edge
    // lets the checker's count catch up with the last transfer.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Write all three registers on consecutive edges; only call this when idle.
    task automatic write_config(input logic en, input logic [MAX_TX_W-1:0] tx_cap,
                                input logic [STAMP_W-1:0] win);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LIMIT_ENABLE;
        i_cfg_data  <= {{(CFG_W-1){1'b0}}, en};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_TRANSMITS;
        i_cfg_data  <= {{(CFG_W-MAX_TX_W){1'b0}}, tx_cap};
        @(posedge i_clk);
        i_cfg_index <= CFG_WINDOW_SECONDS;
        i_cfg_data  <= win;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // Random traffic around a moving clock: mostly records and queries at "now",
    // some queries in the past so that stored stamps lie in the future, counts with
    // short or full-range windows, the odd clear, and a share of pure noise.
    task automatic random_phase(input int items);
        logic [STAMP_W-1:0] clock_now;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] qwin;
        int                 roll;
        t_op                op;
        case ($urandom_range(0, 3))
            0:       clock_now = $urandom_range(0, 40);              // floor goes negative
            1:       clock_now = 32'hFFFF_FFFF - $urandom_range(0, 200); // clock wraps
            default: clock_now = $urandom;
        endcase
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                clock_now += $urandom_range(5, 60);
            else
                clock_now += $urandom_range(0, 3);
            now  = clock_now;
            qwin = $urandom_range(0, 80);
            if (roll < 45) begin
                op = OP_RECORD;
            end else if (roll < 75) begin
                op = OP_QUERY;
                if ($urandom_range(0, 4) == 0)
                    now = clock_now - $urandom_range(1, 10);
            end else if (roll < 90) begin
                op = OP_COUNT;
                if ($urandom_range(0, 4) == 0)
                    qwin = $urandom;
            end else if (roll < 93) begin
                op = OP_CLEAR;
            end else begin
                op   = t_op'($urandom_range(0, 3));
                now  = $urandom;
                qwin = $urandom;
            end
            send_request(op, now, qwin);
            if ($urandom_range(0, 39) == 0)
                gaps_on = !gaps_on;
        end
    endtask

    task automatic run_phase(input logic en, input logic [MAX_TX_W-1:0] tx_cap,
                             input logic [STAMP_W-1:0] win);
        write_config(en, tx_cap, win);
        random_phase(PHASE_ITEMS);
        drain();
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_LIMIT_ENABLE;
        i_cfg_data          <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_RECORD;
        req_ch.now_seconds  <= '0;
        req_ch.query_window <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still at reset: limiter off, nothing stored, ring empty.
        send_request(OP_COUNT,  32'd0,         32'hFFFF_FFFF);
        send_request(OP_QUERY,  32'hFFFF_FFFF, 32'd0);
        send_request(OP_RECORD, 32'd123,       32'd0);
        send_request(OP_COUNT,  32'd200,       32'd100);
        drain();

        // Cap of two in a ten-second window.
        write_config(1'b1, 16'd2, 32'd10);
        send_request(OP_RECORD, 32'd0,         32'd0);
        send_request(OP_RECORD, 32'd5,         32'd0);
        send_request(OP_QUERY,  32'd5,         32'd0);          // blocked, oldest stamp zero
        send_request(OP_QUERY,  32'd20,        32'd0);          // both stamps expired
        send_request(OP_COUNT,  32'd3,         32'hFFFF_FFFF);  // negative floor, future stamp
        send_request(OP_COUNT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_COUNT,  32'd5,         32'd0);          // empty window
        send_request(OP_RECORD, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_RECORD, 32'hFFFF_FFFA, 32'd0);
        send_request(OP_QUERY,  32'hFFFF_FFFF, 32'd0);          // expiry beyond 32 bits
        send_request(OP_COUNT,  32'hFFFF_FFFF, 32'd6);
        send_request(OP_CLEAR,  32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send_request(OP_QUERY,  32'd5,         32'd0);
        send_request(OP_COUNT,  32'd5,         32'hFFFF_FFFF);
        send_request(OP_RECORD, 32'd7,         32'd0);
        send_request(OP_QUERY,  32'd7,         32'd0);          // one hit, under the cap
        drain();

        // Random traffic across register settings, extremes included.
        gaps_on = 1'b1;
        run_phase(1'b1, 16'd4,      32'd40);
        run_phase(1'b1, 16'd1,      32'd1);
        run_phase(1'b1, 16'd16,     32'hFFFF_FFFF);
        run_phase(1'b1, 16'hFFFF,   32'd50);
        run_phase(1'b0, 16'd3,      32'd100);
        run_phase(1'b1, 16'd0,      32'd100);
        run_phase(1'b1, 16'd3,      32'd0);
        run_phase(1'b1, 16'($urandom_range(1, 17)), 32'($urandom_range(1, 300)));
        run_phase(1'b1, 16'd2,      32'd25);

        // Hold a while longer so that any stray verdict is caught.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d record, %0d query, %0d count and %0d clear transfers",
                 sent_per_op[OP_RECORD], sent_per_op[OP_QUERY],
                 sent_per_op[OP_COUNT], sent_per_op[OP_CLEAR]);
        $display("over %0d register settings; %0d blocked verdicts checked",
                 settings_run, blocked_seen);
        if (fail_count == 0)
            $display("sliding_window_rate_limiter_tb passed");
        else
            $display("sliding_window_rate_limiter_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/swrl_pkg.sv
hdl/swrl_in_if.sv
hdl/swrl_out_if.sv
hdl/sliding_window_rate_limiter.sv
tb/swrl_verdict_checker.sv
tb/sliding_window_rate_limiter_tb.sv
